@@ hdl/pmat_pkg.sv @@
// Shared constants, codes and transfer types of the paged memory allocator and translator.
package pmat_pkg;

  localparam int NumFrames   = 256;
  localparam int OffsetBits  = 8;
  localparam int PageBytes   = 1 << OffsetBits;
  localparam int NumProcs    = 8;
  localparam int FrameBits   = (NumFrames > 1) ? $clog2(NumFrames) : 1;
  localparam int ProcBits    = (NumProcs > 1) ? $clog2(NumProcs) : 1;
  localparam int RamBytes    = NumFrames * PageBytes;
  localparam int RamAddrBits = FrameBits + OffsetBits;
  localparam int MapAddrBits = ProcBits + FrameBits;
  localparam int MapDepth    = 1 << MapAddrBits;
  localparam int RamDepth    = 1 << RamAddrBits;
  localparam int VaBits      = 16;
  localparam int SizeBits    = 17;
  localparam int PidBits     = 4;
  localparam int BrkBits     = 17;

  typedef enum logic [1:0] {
    OpAlloc = 2'd0,
    OpFree  = 2'd1,
    OpRead  = 2'd2,
    OpWrite = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  operation;
    logic [PidBits-1:0]   process_id;
    logic [VaBits-1:0]    virt_addr;
    logic [SizeBits-1:0]  alloc_size;
    logic [7:0]           write_data;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [7:0]        read_data;
    logic [VaBits-1:0] alloc_address;
  } rsp_t;

endpackage

@@ hdl/pmat_ram.sv @@
// Generic simple dual-port RAM with registered read.
module pmat_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/paged_memory_allocator_translator.sv @@
// Top level of the paged memory allocator and translator.
//
// Requests arrive on req_valid_i/req_ready_o with a req_t payload: allocate,
// free, read byte or write byte for a process. Each request yields exactly
// one response on rsp_valid_o/rsp_ready_i with a rsp_t payload.
// One request is in work at a time; req_ready_o is high only while idle.
// Steps, request transfer to response valid:
//   read/write: page map read, then byte RAM access;
//   free: page map and frame table reads for each released page, and one
//   more page map read when the chain ends at an unmapped page;
//   allocate: the frame table is swept once to count free frames and once
//   to claim them, one frame a cycle through its single read port; a
//   zero-size allocate skips both sweeps.
// After reset a clearing pass over all RamDepth byte addresses zeroes the byte
// RAM, page map and frame table; no request is taken meanwhile.
// A finished response waits in the output register while the receiver
// stalls; a new request may be taken while it waits, but the next response
// is held until the output register is free.
module paged_memory_allocator_translator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  pmat_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output pmat_pkg::rsp_t rsp_o
);
  import pmat_pkg::*;

  localparam int PgBits  = SizeBits - OffsetBits + 2;
  localparam int CntBits = RamAddrBits + 1;
  localparam int SumBits = BrkBits + 2;
  localparam int FrW     = PidBits + 1;
  localparam int PmW     = FrameBits + 1;

  typedef enum logic [3:0] {
    SClear, SIdle, SDecode, SCount, SCheck, SAlloc,
    SPmRd, SPmChk, SFrChk, SRamData, SDone
  } state_e;

  state_e                 state_q;
  req_t                   req_q;
  rsp_t                   res_q, rsp_q;
  logic                   rsp_valid_q;
  logic [CntBits-1:0]     cnt_q;
  logic                   dv_q, first_q;
  logic [FrameBits-1:0]   addr_q, fsel_q, pv_q;
  logic [FrameBits:0]     free_q;
  logic [PgBits-1:0]      pages_q, k_q;
  logic [BrkBits-1:0]     brk_q [NumProcs];

  logic [ProcBits-1:0]    p;
  logic                   pid_ok;
  logic [PgBits-1:0]      pages_d;
  logic [SumBits-1:0]     brk_end;
  logic [FrameBits:0]     vbase;
  logic [PgBits:0]        vk;
  logic [VaBits-OffsetBits-1:0] va_page;

  logic                   ram_we, pm_we, fr_we;
  logic [RamAddrBits-1:0] ram_waddr, ram_raddr;
  logic [7:0]             ram_wdata, ram_rdata;
  logic [MapAddrBits-1:0] pm_waddr, pm_raddr;
  logic [PmW-1:0]         pm_wdata, pm_rdata;
  logic [FrameBits-1:0]   fr_waddr, fr_raddr;
  logic [FrW-1:0]         fr_wdata, fr_rdata;
  logic                   claim;

  assign p       = ProcBits'(req_q.process_id - PidBits'(1));
  assign pid_ok  = (req_q.process_id >= PidBits'(1)) &&
                   (req_q.process_id <= PidBits'(NumProcs));
  assign pages_d = PgBits'((SumBits'(req_q.alloc_size) + SumBits'(PageBytes - 1))
                           >> OffsetBits);
  assign brk_end = SumBits'(brk_q[p]) + (SumBits'(pages_q) << OffsetBits);
  assign vbase   = (FrameBits + 1)'(brk_q[p] >> OffsetBits);
  assign vk      = (PgBits + 1)'(vbase) + (PgBits + 1)'(k_q);
  assign va_page = req_q.virt_addr[VaBits-1:OffsetBits];
  assign claim   = (state_q == SAlloc) && dv_q && (fr_rdata[FrW-1:1] == '0) &&
                   (k_q < pages_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {pm_rdata[FrameBits-1:0], req_q.virt_addr[OffsetBits-1:0]};
    ram_wdata = req_q.write_data;
    ram_raddr = {pm_rdata[FrameBits-1:0], req_q.virt_addr[OffsetBits-1:0]};
    pm_we     = 1'b0;
    pm_waddr  = {p, pv_q};
    pm_wdata  = '0;
    pm_raddr  = {p, pv_q};
    fr_we     = 1'b0;
    fr_waddr  = fsel_q;
    fr_wdata  = '0;
    fr_raddr  = (state_q == SCount || state_q == SAlloc) ? cnt_q[FrameBits-1:0]
                                                        : pm_rdata[FrameBits-1:0];
    case (state_q)
      SClear: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[RamAddrBits-1:0];
        ram_wdata = '0;
        pm_we     = cnt_q < CntBits'(MapDepth);
        pm_waddr  = cnt_q[MapAddrBits-1:0];
        fr_we     = cnt_q < CntBits'(NumFrames);
        fr_waddr  = cnt_q[FrameBits-1:0];
      end
      SAlloc: begin
        fr_we    = claim;
        fr_waddr = addr_q;
        fr_wdata = {req_q.process_id, (k_q + PgBits'(1)) == pages_q};
        pm_we    = claim && (vk < (PgBits + 1)'(NumFrames));
        pm_waddr = {p, vk[FrameBits-1:0]};
        pm_wdata = {1'b1, addr_q};
      end
      SPmChk: begin
        ram_we = (req_q.operation == OpWrite) && pm_rdata[FrameBits];
      end
      SFrChk: begin
        fr_we = 1'b1;
        pm_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      for (int i = 0; i < NumProcs; i++) brk_q[i] <= '0;
    end else begin
      if (rsp_valid_q && rsp_ready_i && state_q != SDone) rsp_valid_q <= 1'b0;
      case (state_q)
        SClear: begin
          cnt_q <= cnt_q + CntBits'(1);
          if (cnt_q == CntBits'(RamDepth - 1)) state_q <= SIdle;
        end
        SIdle: begin
          if (req_valid_i) begin
            req_q   <= req_i;
            state_q <= SDecode;
          end
        end
        SDecode: begin
          pages_q <= pages_d;
          cnt_q   <= '0;
          dv_q    <= 1'b0;
          free_q  <= '0;
          k_q     <= '0;
          first_q <= 1'b1;
          pv_q    <= va_page[FrameBits-1:0];
          if (pid_ok && req_q.operation == OpAlloc && pages_d == '0) begin
            res_q <= '{status: 1'b0, read_data: '0, alloc_address: brk_q[p][VaBits-1:0]};
          end else begin
            res_q <= '{status: 1'b1, read_data: '0, alloc_address: '0};
          end
          if (!pid_ok) begin
            state_q <= SDone;
          end else if (req_q.operation == OpAlloc) begin
            if (pages_d == '0) begin
              state_q <= SDone;
            end else begin
              state_q <= SCount;
            end
          end else if ((VaBits - OffsetBits + 1)'(va_page) >=
                       (VaBits - OffsetBits + 1)'(NumFrames)) begin
            state_q <= SDone;
          end else begin
            state_q <= SPmRd;
          end
        end
        SCount, SAlloc: begin
          if (state_q == SCount && dv_q && fr_rdata[FrW-1:1] == '0) begin
            free_q <= free_q + (FrameBits + 1)'(1);
          end
          if (claim) k_q <= k_q + PgBits'(1);
          addr_q <= cnt_q[FrameBits-1:0];
          if (cnt_q == CntBits'(NumFrames)) begin
            dv_q <= 1'b0;
            if (state_q == SCount) begin
              state_q <= SCheck;
            end else begin
              brk_q[p] <= BrkBits'(brk_end);
              res_q    <= '{status: 1'b0, read_data: '0, alloc_address: brk_q[p][VaBits-1:0]};
              state_q  <= SDone;
            end
          end else begin
            dv_q  <= 1'b1;
            cnt_q <= cnt_q + CntBits'(1);
          end
        end
        SCheck: begin
          cnt_q <= '0;
          if (PgBits'(free_q) >= pages_q && brk_end <= SumBits'(RamBytes)) begin
            state_q <= SAlloc;
          end else begin
            state_q <= SDone;
          end
        end
        SPmRd: state_q <= SPmChk;
        SPmChk: begin
          first_q <= 1'b0;
          fsel_q  <= pm_rdata[FrameBits-1:0];
          if (!pm_rdata[FrameBits]) begin
            if (req_q.operation == OpFree && !first_q) res_q.status <= 1'b0;
            state_q <= SDone;
          end else begin
            case (req_q.operation)
              OpFree:  state_q <= SFrChk;
              OpRead:  state_q <= SRamData;
              default: begin
                res_q.status <= 1'b0;
                state_q      <= SDone;
              end
            endcase
          end
        end
        SFrChk: begin
          if (fr_rdata[0] || pv_q == FrameBits'(NumFrames - 1)) begin
            res_q.status <= 1'b0;
            state_q      <= SDone;
          end else begin
            pv_q    <= pv_q + FrameBits'(1);
            state_q <= SPmRd;
          end
        end
        SRamData: begin
          res_q   <= '{status: 1'b0, read_data: ram_rdata, alloc_address: '0};
          state_q <= SDone;
        end
        SDone: begin
          if (!rsp_valid_q || rsp_ready_i) begin
            rsp_q       <= res_q;
            rsp_valid_q <= 1'b1;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign req_ready_o = (state_q == SIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  pmat_ram #(.Width(8), .Depth(RamDepth)) u_byte_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  pmat_ram #(.Width(PmW), .Depth(MapDepth)) u_page_map (
    .clk_i, .we_i(pm_we), .waddr_i(pm_waddr), .wdata_i(pm_wdata),
    .raddr_i(pm_raddr), .rdata_o(pm_rdata)
  );

  pmat_ram #(.Width(FrW), .Depth(1 << FrameBits)) u_frame_tab (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );

endmodule

@@ hdl/pmat_checker.sv @@
// Port-level assertions for the paged memory allocator and translator, with bind.
module pmat_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input pmat_pkg::rsp_t rsp_o
);
  import pmat_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response dropped or changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status |-> rsp_o.read_data == '0 && rsp_o.alloc_address == '0)
    else $error("failed response carries data");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken while one is in work");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !req_ready_o && !rsp_valid_o)
    else $error("handshake active in reset");

endmodule

bind paged_memory_allocator_translator pmat_checker u_pmat_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o
);

@@ test/paged_memory_allocator_translator_tb.sv @@
// Testbench: random and directed requests against a behavioural model of the paged allocator.
module paged_memory_allocator_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmat_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  paged_memory_allocator_translator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i), .req_ready_o(req_ready_o),
    .req_i(req_i), .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
  );

  always #4 clk_i = ~clk_i;

  logic [7:0]      mem_bytes [RamBytes];
  logic [3:0]      owner_of [NumFrames];
  logic            last_of [NumFrames];
  logic            map_ok [NumProcs][NumFrames];
  logic [7:0]      map_frame [NumProcs][NumFrames];
  logic [BrkBits:0] brk [NumProcs];

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   fail_count = 0;
  bit   calm = 1'b0;
  bit   stim_done = 1'b0;
  int   req_gap = 0;
  int   rsp_gap = 0;

  function automatic bit lookup(int p, logic [15:0] va, output int phys);
    int vp;
    vp = int'(va >> OffsetBits);
    phys = 0;
    if (vp >= NumFrames || !map_ok[p][vp]) return 1'b0;
    phys = int'(map_frame[p][vp]) * PageBytes + (int'(va) % PageBytes);
    return 1'b1;
  endfunction

  function automatic rsp_t translate_op(req_t r);
    rsp_t o;
    int p, phys, pages, nfree, k, vp, f;
    bit fin;
    o = '0;
    o.status = 1'b1;
    if (r.process_id < 1 || r.process_id > NumProcs) return o;
    p = int'(r.process_id) - 1;
    case (r.operation)
      OpAlloc: begin
        pages = (int'(r.alloc_size) + PageBytes - 1) / PageBytes;
        nfree = 0;
        foreach (owner_of[i]) if (owner_of[i] == 0) nfree++;
        if (pages == 0) begin
          o.status = 1'b0;
          o.alloc_address = brk[p][15:0];
        end else if (nfree >= pages && brk[p] + pages * PageBytes <= RamBytes) begin
          o.status = 1'b0;
          o.alloc_address = brk[p][15:0];
          vp = int'(brk[p]) / PageBytes;
          k = 0;
          for (f = 0; f < NumFrames && k < pages; f++) begin
            if (owner_of[f] == 0) begin
              owner_of[f] = r.process_id;
              last_of[f] = (k + 1 == pages);
              if (vp + k < NumFrames) begin
                map_ok[p][vp + k] = 1'b1;
                map_frame[p][vp + k] = 8'(f);
              end
              k++;
            end
          end
          brk[p] = (BrkBits + 1)'(int'(brk[p]) + pages * PageBytes);
        end
      end
      OpFree: begin
        if (lookup(p, r.virt_addr, phys)) begin
          o.status = 1'b0;
          vp = int'(r.virt_addr >> OffsetBits);
          fin = 1'b0;
          while (vp < NumFrames && !fin && map_ok[p][vp]) begin
            f = int'(map_frame[p][vp]);
            fin = last_of[f];
            owner_of[f] = '0;
            last_of[f] = 1'b0;
            map_ok[p][vp] = 1'b0;
            vp++;
          end
        end
      end
      OpRead: begin
        if (lookup(p, r.virt_addr, phys)) begin
          o.status = 1'b0;
          o.read_data = mem_bytes[phys];
        end
      end
      default: begin
        if (lookup(p, r.virt_addr, phys)) begin
          o.status = 1'b0;
          mem_bytes[phys] = r.write_data;
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_o) begin
        expected_rsps.push_back(translate_op(req_i));
      end
      if (!req_valid_i || req_ready_o) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          req_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_i <= pending_reqs.pop_front();
          req_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 13);
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $error("response with nothing expected");
          fail_count++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_o.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, rsp_o.status);
            fail_count++;
          end
          if (rsp_o.read_data !== e.read_data) begin
            $error("read_data: expected %0d actual %0d", e.read_data, rsp_o.read_data);
            fail_count++;
          end
          if (rsp_o.alloc_address !== e.alloc_address) begin
            $error("alloc_address: expected %0d actual %0d", e.alloc_address,
                   rsp_o.alloc_address);
            fail_count++;
          end
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_gap <= $urandom_range(0, 12);
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= 1'b1;
      end
    end
  end

  function automatic req_t make_req(op_e op, int pid, int va, int sz, int wd);
    req_t r;
    r.operation = op;
    r.process_id = PidBits'(pid);
    r.virt_addr = VaBits'(va);
    r.alloc_size = SizeBits'(sz);
    r.write_data = 8'(wd);
    return r;
  endfunction

  function automatic int pick_addr(int pid);
    int p;
    p = (pid >= 1 && pid <= NumProcs) ? pid - 1 : 0;
    if (brk[p] > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, brk[p] - 1) & 16'hffff;
    return $urandom_range(0, 65535);
  endfunction

  initial begin
    int pid, sz, op;
    foreach (mem_bytes[i]) mem_bytes[i] = '0;
    foreach (owner_of[i]) begin
      owner_of[i] = '0;
      last_of[i] = 1'b0;
    end
    foreach (map_ok[i, j]) begin
      map_ok[i][j] = 1'b0;
      map_frame[i][j] = '0;
    end
    foreach (brk[i]) brk[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_reqs.push_back(make_req(OpRead, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OpAlloc, 0, 0, 100, 0));
    pending_reqs.push_back(make_req(OpAlloc, 9, 0, 100, 0));
    pending_reqs.push_back(make_req(OpWrite, 15, 16'hffff, 0, 8'hff));
    pending_reqs.push_back(make_req(OpRead, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(OpAlloc, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(OpAlloc, 1, 16'hffff, 1, 8'hff));
    pending_reqs.push_back(make_req(OpWrite, 1, 16'h00ff, 0, 8'hff));
    pending_reqs.push_back(make_req(OpAlloc, 2, 0, 513, 0));
    pending_reqs.push_back(make_req(OpWrite, 2, 16'h0201, 0, 8'ha5));
    pending_reqs.push_back(make_req(OpRead, 2, 16'h0201, 0, 0));
    pending_reqs.push_back(make_req(OpRead, 1, 16'h00ff, 0, 0));
    pending_reqs.push_back(make_req(OpFree, 2, 16'h0180, 0, 0));
    pending_reqs.push_back(make_req(OpRead, 2, 16'h0201, 0, 0));
    pending_reqs.push_back(make_req(OpRead, 2, 16'h0000, 0, 0));
    pending_reqs.push_back(make_req(OpAlloc, 3, 0, 65536, 0));
    pending_reqs.push_back(make_req(OpAlloc, 8, 0, 131071, 0));
    pending_reqs.push_back(make_req(OpAlloc, 8, 0, 65536 - 1024, 0));
    pending_reqs.push_back(make_req(OpAlloc, 8, 0, 1024, 0));
    pending_reqs.push_back(make_req(OpWrite, 8, 16'hffff, 0, 8'h5a));
    pending_reqs.push_back(make_req(OpRead, 8, 16'hffff, 0, 0));
    pending_reqs.push_back(make_req(OpAlloc, 8, 0, 256, 0));
    pending_reqs.push_back(make_req(OpFree, 8, 16'h0000, 0, 0));
    pending_reqs.push_back(make_req(OpFree, 8, 16'hfc00, 0, 0));
    pending_reqs.push_back(make_req(OpFree, 1, 16'h0000, 0, 0));
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk_i);
    // random; addresses come from the model state as it stands when queued
    for (int n = 0; n < 1900; n++) begin
      if (n == 1700) calm = 1'b1;
      pid = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, NumProcs);
      op = $urandom_range(0, 9);
      if (op < 2) begin
        sz = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 2048);
        pending_reqs.push_back(make_req(OpAlloc, pid, $urandom_range(0, 65535), sz,
                                        $urandom_range(0, 255)));
      end else if (op < 3) begin
        pending_reqs.push_back(make_req(OpFree, pid, pick_addr(pid), $urandom_range(0, 131071),
                                        $urandom_range(0, 255)));
      end else begin
        pending_reqs.push_back(make_req(op < 6 ? OpRead : OpWrite, pid, pick_addr(pid),
                                        $urandom_range(0, 131071), $urandom_range(0, 255)));
      end
      while (pending_reqs.size() > 0) @(posedge clk_i);
    end
    while (req_valid_i || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("FAILURE");
    $finish;
  end

endmodule
